/* rtl/crc16_hex_ascii_frame_encoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// crc16_hex_ascii_frame_encoder_unit_macros.svh
// Assertion macros used by the frame encoder RTL (the character sequencer).
// ----------------------------------------------------------------------------
`ifndef CRC16_HEX_ASCII_FRAME_ENCODER_UNIT_MACROS_SVH
`define CRC16_HEX_ASCII_FRAME_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CRC16H_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc16h assertion failed");

// next-cycle implication, disabled in reset
`define CRC16H_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc16h assertion failed");

`endif

/* rtl/crc16h_pkg.sv */
// ----------------------------------------------------------------------------
// crc16h_pkg
// Types, constants and helper functions of the CRC-16 hex-ASCII frame encoder.
// ----------------------------------------------------------------------------
package crc16h_pkg;

    localparam logic [7:0]  START_CHAR  = 8'h02;
    localparam logic [7:0]  END_CHAR    = 8'h03;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  ASCII_ZERO  = 8'd48;
    localparam logic [7:0]  ASCII_ALPHA = 8'd55;   // 'A' - 10
    localparam logic [3:0]  MAX_DIGIT   = 4'd9;
    localparam int          QUEUE_DEPTH = 2;

    // input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // output character
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
    } t_out;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] crc;     // CRC including this byte
    } t_job;

    // emission steps of the back end
    typedef enum logic [2:0] {
        ST_START,
        ST_DHI,
        ST_DLO,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_END
    } t_step;

    // nibble to upper-case hex ASCII
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        return (nib <= MAX_DIGIT) ? (wide + ASCII_ZERO) : (wide + ASCII_ALPHA);
    endfunction

    // one byte of CRC-16/CCITT-FALSE, poly 0x1021
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'd0, x[7:4]};
        return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
    endfunction

endpackage

/* rtl/crc16h_fifo.sv */
// ----------------------------------------------------------------------------
// crc16h_fifo
// Small register queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module crc16h_fifo
    import crc16h_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_wdata,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_SLOT) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_SLOT) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

/* rtl/crc16h_front.sv */
// ----------------------------------------------------------------------------
// crc16h_front
// Accepts input requests, tracks frame boundaries and the running CRC.
// ----------------------------------------------------------------------------
module crc16h_front
    import crc16h_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_full,
    output logic o_push,
    output t_job o_job
);

    logic        r_in_frame;
    logic [15:0] r_crc;
    logic [15:0] crc_base;
    logic [15:0] crc_next;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    // CRC restarts at the first byte of a frame
    assign crc_base = r_in_frame ? r_crc : CRC_INIT;
    assign crc_next = crc_update(crc_base, i_in_data.data_byte);

    always_comb begin
        o_job.data  = i_in_data.data_byte;
        o_job.first = !r_in_frame;
        o_job.last  = i_in_data.last_byte;
        o_job.crc   = crc_next;
    end

    // frame state and running CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_crc      <= CRC_INIT;
        end else if (o_push) begin
            r_in_frame <= !i_in_data.last_byte;
            r_crc      <= i_in_data.last_byte ? CRC_INIT : crc_next;
        end
    end

endmodule

/* rtl/crc16h_back.sv */
// ----------------------------------------------------------------------------
// crc16h_back
// Character sequencer: expands each queued byte into its output characters.
// ----------------------------------------------------------------------------
`include "crc16_hex_ascii_frame_encoder_unit_macros.svh"

module crc16h_back
    import crc16h_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_step r_step, n_step;
    t_step eff_step;
    logic  advance;
    logic  is_final;
    logic  r_out_valid;
    t_out  r_out;
    t_out  n_out;

    // a job without a start character begins at its high digit
    assign eff_step = (r_step == ST_START && !i_job.first) ? ST_DHI : r_step;
    assign is_final = (eff_step == ST_END) || (eff_step == ST_DLO && !i_job.last);
    assign advance  = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_pop    = advance && is_final;

    // next step
    always_comb begin
        n_step = r_step;
        if (advance) begin
            if (is_final) begin
                n_step = ST_START;
            end else begin
                unique case (eff_step)
                    ST_START: n_step = ST_DHI;
                    ST_DHI:   n_step = ST_DLO;
                    ST_DLO:   n_step = ST_C0;
                    ST_C0:    n_step = ST_C1;
                    ST_C1:    n_step = ST_C2;
                    ST_C2:    n_step = ST_C3;
                    ST_C3:    n_step = ST_END;
                    ST_END:   n_step = ST_START;
                endcase
            end
        end
    end

    // character for the current step
    always_comb begin
        n_out.run_end = is_final;
        unique case (eff_step)
            ST_START: n_out.out_char = START_CHAR;
            ST_DHI:   n_out.out_char = hex_char(i_job.data[7:4]);
            ST_DLO:   n_out.out_char = hex_char(i_job.data[3:0]);
            ST_C0:    n_out.out_char = hex_char(i_job.crc[7:4]);
            ST_C1:    n_out.out_char = hex_char(i_job.crc[3:0]);
            ST_C2:    n_out.out_char = hex_char(i_job.crc[15:12]);
            ST_C3:    n_out.out_char = hex_char(i_job.crc[11:8]);
            ST_END:   n_out.out_char = END_CHAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_START;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CRC16H_ASSERT_NOW(a_pop_has_job, i_clk, i_rst_n, o_pop, i_job_valid)
    `CRC16H_ASSERT_NOW(a_end_closes, i_clk, i_rst_n,
        r_out_valid && r_out.out_char == END_CHAR, r_out.run_end)
    `CRC16H_ASSERT_NOW(a_start_open, i_clk, i_rst_n,
        r_out_valid && r_out.out_char == START_CHAR, !r_out.run_end)
    `CRC16H_ASSERT_NEXT(a_mid_job, i_clk, i_rst_n,
        advance && !is_final, r_step != ST_START)

endmodule

/* rtl/crc16_hex_ascii_frame_encoder_unit.sv */
// A request enters the queue, then its first character is registered in the output register.
// Throughput: one character per cycle while a byte is queued and output is ready; a middle byte
// gives 2 characters, a first byte 3, a closing byte 7, a one-byte frame 8, via one output register.
// A 2-entry queue (QUEUE_DEPTH) lets intake run ahead of the character sequencer.
// Reset (synchronous, active low) closes any open frame without an end character,
// sets the CRC to 0xFFFF and empties the queue and the output register.
// ----------------------------------------------------------------------------
// crc16_hex_ascii_frame_encoder_unit
// Top level: CRC-16/CCITT-FALSE framed hex-ASCII encoder.
// ----------------------------------------------------------------------------
module crc16_hex_ascii_frame_encoder_unit
    import crc16h_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic full;
    logic push;
    t_job push_job;
    logic job_valid;
    t_job head_job;
    logic pop;

    // intake and classification
    crc16h_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decoupling queue
    crc16h_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_rdata (head_job)
    );

    // character sequencer
    crc16h_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-16 hex-ASCII frame encoder.
// Command bytes are pushed in as frames. A tracker models the framing: start
// character, hex digits, CRC digits and end character. Every output character
// is compared against it in order. Both channels see random gaps, and one long
// output hold-off backs the encoder up until it stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import crc16h_pkg::*;

    localparam logic [15:0] CCITT_POLY   = 16'h1021;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_BYTES = 130;

    typedef logic [7:0] t_byte_list[$];

    // ------------------------------------------------------------------------
    // Expected character tracker: models framing and CRC, and checks output
    // ------------------------------------------------------------------------
    class t_hex_frame_tracker;
        t_out        pending_chars[$];
        logic [15:0] crc_run;
        logic        frame_open;
        int          errors;
        int          chars_seen;
        int          frames_closed;
        int          bytes_taken;

        function new();
            crc_run       = CRC_INIT;
            frame_open    = 1'b0;
            errors        = 0;
            chars_seen    = 0;
            frames_closed = 0;
            bytes_taken   = 0;
        endfunction

        // bit-serial CRC-16/CCITT-FALSE over one byte
        function logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                c = c[15] ? ((c << 1) ^ CCITT_POLY) : (c << 1);
            end
            return c;
        endfunction

        function logic [7:0] hex_digit(input logic [3:0] nib);
            return (nib < 4'd10) ? (ASCII_ZERO + {4'd0, nib}) : (ASCII_ALPHA + {4'd0, nib});
        endfunction

        function void push_char(input logic [7:0] ch, input logic mark);
            t_out e;
            e.out_char = ch;
            e.run_end  = mark;
            pending_chars.insert(pending_chars.size(), e);
        endfunction

        // accepted request: queue up every character it produces
        function void note_request(input t_in req);
            bytes_taken++;
            if (!frame_open) begin
                push_char(START_CHAR, 1'b0);
                frame_open = 1'b1;
                crc_run    = CRC_INIT;
            end
            push_char(hex_digit(req.data_byte[7:4]), 1'b0);
            push_char(hex_digit(req.data_byte[3:0]), !req.last_byte);
            crc_run = crc_after(crc_run, req.data_byte);
            if (req.last_byte) begin
                // low CRC byte first, each byte high nibble first
                push_char(hex_digit(crc_run[7:4]), 1'b0);
                push_char(hex_digit(crc_run[3:0]), 1'b0);
                push_char(hex_digit(crc_run[15:12]), 1'b0);
                push_char(hex_digit(crc_run[11:8]), 1'b0);
                push_char(END_CHAR, 1'b1);
                crc_run    = CRC_INIT;
                frame_open = 1'b0;
                frames_closed++;
            end
        endfunction

        // accepted output character: compare with the oldest expectation
        function void check_char(input t_out got);
            t_out want;
            chars_seen++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected char: expected none, actual %h/%b",
                         $time, got.out_char, got.run_end);
                return;
            end
            want = pending_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                errors++;
                $display("%0t: out_char: expected %h, actual %h",
                         $time, want.out_char, got.out_char);
            end
            if (got.run_end !== want.run_end) begin
                errors++;
                $display("%0t: run_end: expected %b, actual %b",
                         $time, want.run_end, got.run_end);
            end
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    logic out_ready   = 1'b0;
    t_in  in_data     = '0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    logic idle_on      = 1'b0;
    logic hold_pending = 1'b0;
    int   cycle_count  = 0;

    t_hex_frame_tracker tracker = new();

    crc16_hex_ascii_frame_encoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // handshakes decided at the next rising edge; inputs are stable mid-cycle
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready)
                tracker.note_request(in_data);
            if (out_valid && out_ready)
                tracker.check_char(out_data);
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int g;
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pending = 1'b0;
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            g = idle_on ? pick_gap() : 0;
            if (g > 0) begin
                out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // offer one request and hold it until accepted, then maybe idle
    task automatic send_request(input logic [7:0] b, input logic last);
        int g;
        in_valid            <= 1'b1;
        in_data.data_byte   <= b;
        in_data.last_byte   <= last;
        do @(negedge i_clk); while (!in_ready);
        @(posedge i_clk);
        g = idle_on ? pick_gap() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input t_byte_list bytes);
        foreach (bytes[i])
            send_request(bytes[i], i == bytes.size() - 1);
    endtask

    function automatic t_byte_list random_frame(input int len);
        t_byte_list q;
        for (int i = 0; i < len; i++)
            q.insert(q.size(), 8'($urandom));
        return q;
    endfunction

    initial begin
        t_byte_list frame;
        int         sent;
        int         len;
        int         r;
        int         frame_idx;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one-byte frames at the extremes, the CRC check string,
        // nibble patterns, a two-byte frame; back to back, no idling
        send_frame('{8'h00});
        send_frame('{8'hFF});
        send_frame('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39});
        send_frame('{8'hF0, 8'h0F, 8'hA5, 8'h5A});
        send_frame('{8'h80, 8'h01});

        // random frames, mostly short; one long frame under an output hold-off
        idle_on   = 1'b1;
        sent      = 0;
        frame_idx = 0;
        while (sent < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (frame_idx == 4) begin
                hold_pending = 1'b1;
                len = 16;
            end else if (r < 60)
                len = $urandom_range(1, 4);
            else if (r < 90)
                len = $urandom_range(5, 10);
            else
                len = $urandom_range(11, 24);
            // a stretch of frames without any gaps
            idle_on = !(frame_idx >= 10 && frame_idx < 14);
            frame = random_frame(len);
            send_frame(frame);
            sent += len;
            frame_idx++;
        end
        in_valid <= 1'b0;

        while (tracker.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.pending_chars.size() != 0) begin
            tracker.errors++;
            $display("%0t: %0d expected chars never arrived",
                     $time, tracker.pending_chars.size());
        end
        $display("covered %0d bytes in %0d frames, %0d chars checked, %0d cycles",
                 tracker.bytes_taken, tracker.frames_closed, tracker.chars_seen,
                 cycle_count);
        $display("included one-byte frames, long frames and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
